/* hdl/kms_pkg.sv */
// Shared types, widths and helpers for the keypad matrix scanner.
`timescale 1ns / 1ps

package kms_pkg;

    localparam int unsigned ROW_COUNT    = 4;
    localparam int unsigned COLUMN_COUNT = 4;
    localparam int unsigned KEY_COUNT    = ROW_COUNT * COLUMN_COUNT;
    localparam int unsigned COLUMN_W     = $clog2(COLUMN_COUNT);
    localparam int unsigned BTN_COUNT    = 3;
    localparam int unsigned FLAG_COUNT   = 2 * BTN_COUNT;

    localparam int unsigned IN_DATA_W  = 16;
    localparam int unsigned OUT_DATA_W = 48;

    localparam logic [COLUMN_W-1:0] LAST_COLUMN = COLUMN_W'(COLUMN_COUNT - 1);

    // Result of one matrix sample
    typedef struct packed {
        logic [COLUMN_COUNT-1:0] column_drive;
        logic                    scan_done;
        logic [KEY_COUNT-1:0]    key_word;
        logic [KEY_COUNT-1:0]    key_down_mask;
    } scan_result_t;

    // Result of one button sample
    typedef struct packed {
        logic [BTN_COUNT-1:0]  sys_pressed;
        logic [FLAG_COUNT-1:0] sys_flags;
    } btn_result_t;

    // Spread active-high row bits of one column into key positions 4*row+column
    function automatic logic [KEY_COUNT-1:0] column_bits(
        input logic [ROW_COUNT-1:0] pressed_rows,
        input logic [COLUMN_W-1:0]  col
    );
        logic [KEY_COUNT-1:0] bits;
        bits = '0;
        for (int r = 0; r < ROW_COUNT; r++)
        begin
            for (int c = 0; c < COLUMN_COUNT; c++)
            begin
                if (col == COLUMN_W'(c))
                begin
                    bits[r * COLUMN_COUNT + c] = pressed_rows[r];
                end
            end
        end
        return bits;
    endfunction

endpackage

/* hdl/kms_matrix.sv */
// Column scan state and per-scan key word with new-press detection.
`timescale 1ns / 1ps

module kms_matrix
    import kms_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step_en,
    input  logic [ROW_COUNT-1:0] row_sense,
    output scan_result_t         result
);

    logic [COLUMN_W-1:0]  column_reg;
    logic [COLUMN_W-1:0]  column_next;
    logic [KEY_COUNT-1:0] partial_reg;
    logic [KEY_COUNT-1:0] partial_next;
    logic [KEY_COUNT-1:0] stable_reg;
    logic [KEY_COUNT-1:0] stable_next;
    logic [KEY_COUNT-1:0] merged;
    logic                 last_col;

    // Merge this column's pressed rows and close the scan on the last column
    always_comb
    begin
        merged      = partial_reg | column_bits(~row_sense, column_reg);
        last_col    = (column_reg == LAST_COLUMN);
        column_next = column_reg + COLUMN_W'(1);
        if (last_col)
        begin
            partial_next = '0;
            stable_next  = merged;
        end
        else
        begin
            partial_next = merged;
            stable_next  = stable_reg;
        end
        result.column_drive  = ~(COLUMN_COUNT'(1) << column_next);
        result.scan_done     = last_col;
        result.key_word      = stable_next;
        result.key_down_mask = last_col ? (merged & ~stable_reg) : '0;
    end

    // Advance scan state on each processed item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg  <= '0;
            partial_reg <= '0;
            stable_reg  <= '0;
        end
        else if (step_en)
        begin
            column_reg  <= column_next;
            partial_reg <= partial_next;
            stable_reg  <= stable_next;
        end
    end

endmodule

/* hdl/kms_buttons.sv */
// Button press levels and sticky down/up flags with clear requests.
`timescale 1ns / 1ps

module kms_buttons
    import kms_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step_en,
    input  logic [BTN_COUNT-1:0]  sys_pins,
    input  logic [FLAG_COUNT-1:0] flag_clear,
    output btn_result_t           result
);

    logic [BTN_COUNT-1:0]  levels_reg;
    logic [BTN_COUNT-1:0]  levels_next;
    logic [FLAG_COUNT-1:0] flags_reg;
    logic [FLAG_COUNT-1:0] flags_next;

    // Drop cleared flags first, then record this item's level changes
    always_comb
    begin
        levels_next = ~sys_pins;
        flags_next  = flags_reg & ~flag_clear;
        for (int b = 0; b < BTN_COUNT; b++)
        begin
            if (levels_reg[b] != levels_next[b])
            begin
                flags_next[2 * b]     = levels_next[b];
                flags_next[2 * b + 1] = ~levels_next[b];
            end
        end
        result.sys_pressed = levels_next;
        result.sys_flags   = flags_next;
    end

    // Hold button state between items
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            levels_reg <= '0;
            flags_reg  <= '0;
        end
        else if (step_en)
        begin
            levels_reg <= levels_next;
            flags_reg  <= flags_next;
        end
    end

endmodule

/* hdl/keypad_matrix_scanner.sv */
// Top level: input register, scan and button logic, output register.
`timescale 1ns / 1ps

// Path: an accepted item passes the input register, then the result register.
// Throughput: one item per cycle while m_axis_tready holds; the input register can still fill while the result stalls.
// Reset (rst_n, async, active low) clears column index, scan words, button levels,
// sticky flags and both valid flags; column 0 is the first one sampled.
module keypad_matrix_scanner
    import kms_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [3:0] row_sense, [6:4] sys_pins, [12:7] flag_clear, [15:13] zero
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [3:0] column_drive, [19:4] key_word, [35:20] key_down_mask,
    // [38:36] sys_pressed, [44:39] sys_flags, [47:45] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tlast    // scan_done
);

    localparam int unsigned PAYLOAD_W = COLUMN_COUNT + 2 * KEY_COUNT + BTN_COUNT + FLAG_COUNT;

    logic                  in_valid_reg;
    logic [ROW_COUNT-1:0]  rows_reg;
    logic [BTN_COUNT-1:0]  pins_reg;
    logic [FLAG_COUNT-1:0] clear_reg;
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic                  out_last_reg;
    logic                  out_free;
    logic                  advance;
    scan_result_t          scan_res;
    btn_result_t           btn_res;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;

    // Capture accepted items
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            rows_reg  <= s_axis_tdata[ROW_COUNT-1:0];
            pins_reg  <= s_axis_tdata[ROW_COUNT +: BTN_COUNT];
            clear_reg <= s_axis_tdata[ROW_COUNT + BTN_COUNT +: FLAG_COUNT];
        end
    end

    kms_matrix u_matrix (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (advance),
        .row_sense (rows_reg),
        .result    (scan_res)
    );

    kms_buttons u_buttons (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_en    (advance),
        .sys_pins   (pins_reg),
        .flag_clear (clear_reg),
        .result     (btn_res)
    );

    // Load result register when the output side is free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= {(OUT_DATA_W - PAYLOAD_W)'(0),
                             btn_res.sys_flags,
                             btn_res.sys_pressed,
                             scan_res.key_down_mask,
                             scan_res.key_word,
                             scan_res.column_drive};
            out_last_reg <= scan_res.scan_done;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for the keypad matrix scanner.
`timescale 1ns / 1ps

module tb_top;
    import kms_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int unsigned DRAIN_CYCLES  = 8;
    localparam int unsigned RANDOM_GROUPS = 225;
    localparam int unsigned CALM_FIRST    = 400;
    localparam int unsigned CALM_LAST     = 600;

    // One expected or observed result: scan part and button part
    typedef struct packed {
        scan_result_t scan;
        btn_result_t  btn;
    } sample_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // [3:0] row_sense, [6:4] sys_pins, [12:7] flag_clear, [15:13] zero
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [3:0] column_drive, [19:4] key_word, [35:20] key_down_mask,
    // [38:36] sys_pressed, [44:39] sys_flags, [47:45] zero
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;

    // Stimulus and expected results
    logic [IN_DATA_W-1:0] sample_q[$];
    sample_result_t       pending_results[$];

    // Scanner model state
    logic [COLUMN_W-1:0]   col_idx = '0;
    logic [KEY_COUNT-1:0]  scan_acc = '0;
    logic [KEY_COUNT-1:0]  held_keys = '0;
    logic [BTN_COUNT-1:0]  btn_levels = '0;
    logic [FLAG_COUNT-1:0] btn_flags = '0;

    int unsigned cycle_count = 0;
    int unsigned items_queued = 0;
    int unsigned items_sent = 0;
    int unsigned results_seen = 0;
    int unsigned scans_seen = 0;
    int unsigned key_downs_seen = 0;
    int unsigned error_count = 0;
    bit          item_taken = 1'b0;

    wire calm_window = (items_sent >= CALM_FIRST) && (items_sent < CALM_LAST);

    keypad_matrix_scanner dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #4 clk = ~clk;

    // Roll for an idle cycle, none inside the calm window
    function automatic bit idle_roll();
        return !calm_window && ($urandom_range(99) < 28);
    endfunction

    // Advance the scanner model by one sample and return its result
    function automatic sample_result_t predict_sample(input logic [IN_DATA_W-1:0] item);
        logic [ROW_COUNT-1:0]  rows;
        logic [BTN_COUNT-1:0]  pins;
        logic [BTN_COUNT-1:0]  levels_now;
        logic [FLAG_COUNT-1:0] clr;
        sample_result_t        res;
        rows = item[3:0];
        pins = item[6:4];
        clr  = item[12:7];
        res  = '0;
        // Matrix: a low row line marks the key at this column
        for (int r = 0; r < ROW_COUNT; r++)
        begin
            if (!rows[r])
            begin
                scan_acc[r * COLUMN_COUNT + int'(col_idx)] = 1'b1;
            end
        end
        if (col_idx == LAST_COLUMN)
        begin
            res.scan.key_down_mask = scan_acc & ~held_keys;
            res.scan.scan_done     = 1'b1;
            held_keys              = scan_acc;
            scan_acc               = '0;
        end
        col_idx = col_idx + COLUMN_W'(1);
        // Buttons: clear first, then this sample's edges win
        btn_flags  = btn_flags & ~clr;
        levels_now = ~pins;
        for (int b = 0; b < BTN_COUNT; b++)
        begin
            if (btn_levels[b] != levels_now[b])
            begin
                btn_flags[2 * b]     = levels_now[b];
                btn_flags[2 * b + 1] = !levels_now[b];
            end
        end
        btn_levels = levels_now;
        res.scan.column_drive = ~(COLUMN_COUNT'(1) << col_idx);
        res.scan.key_word     = held_keys;
        res.btn.sys_pressed   = btn_levels;
        res.btn.sys_flags     = btn_flags;
        return res;
    endfunction

    // Report one field mismatch
    task automatic check_field(input string name, input logic [KEY_COUNT-1:0] want,
                               input logic [KEY_COUNT-1:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            error_count++;
        end
    endtask

    // Queue one sample
    task automatic push_sample(input logic [ROW_COUNT-1:0] rows,
                               input logic [BTN_COUNT-1:0] pins,
                               input logic [FLAG_COUNT-1:0] clr);
        sample_q.push_back({3'b000, clr, pins, rows});
        items_queued++;
    endtask

    // Queue one full scan of a key pattern, buttons held, clear on column 0
    task automatic push_scan(input logic [KEY_COUNT-1:0] keys,
                             input logic [BTN_COUNT-1:0] pins,
                             input logic [FLAG_COUNT-1:0] clr);
        logic [ROW_COUNT-1:0] rows;
        for (int c = 0; c < COLUMN_COUNT; c++)
        begin
            for (int r = 0; r < ROW_COUNT; r++)
            begin
                rows[r] = !keys[r * COLUMN_COUNT + c];
            end
            push_sample(rows, pins, (c == 0) ? clr : '0);
        end
    endtask

    // Queue one random group: mostly coherent scans, some noise
    task automatic push_random_group(inout logic [KEY_COUNT-1:0] keys,
                                     inout logic [BTN_COUNT-1:0] pins);
        logic [ROW_COUNT-1:0]  rows;
        logic [BTN_COUNT-1:0]  pins_now;
        logic [FLAG_COUNT-1:0] clr;
        if ($urandom_range(99) < 80)
        begin
            // Evolve the held keys a little, now and then jump
            if ($urandom_range(9) == 0)
            begin
                keys = KEY_COUNT'($urandom & $urandom);
            end
            else
            begin
                repeat ($urandom_range(3))
                begin
                    keys[$urandom_range(KEY_COUNT - 1)] ^= 1'b1;
                end
            end
            if ($urandom_range(9) < 3)
            begin
                pins = BTN_COUNT'($urandom);
            end
            for (int c = 0; c < COLUMN_COUNT; c++)
            begin
                for (int r = 0; r < ROW_COUNT; r++)
                begin
                    rows[r] = !keys[r * COLUMN_COUNT + c];
                end
                pins_now = ($urandom_range(9) == 0) ? BTN_COUNT'($urandom) : pins;
                clr = ($urandom_range(4) == 0) ? FLAG_COUNT'($urandom) : '0;
                push_sample(rows, pins_now, clr);
            end
        end
        else
        begin
            repeat (COLUMN_COUNT)
            begin
                push_sample(ROW_COUNT'($urandom), BTN_COUNT'($urandom),
                            FLAG_COUNT'($urandom));
            end
        end
    endtask

    // Driver: present queued items at the falling edge, hold until taken
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_axis_tvalid || item_taken)
            begin
                if (sample_q.size() > 0 && !idle_roll())
                begin
                    s_axis_tdata  <= sample_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            item_taken = 1'b0;
            m_axis_tready <= !idle_roll();
        end
    end

    // Monitor: check the result first, then predict from the accepted item
    always @(posedge clk)
    begin
        sample_result_t want;
        sample_result_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.scan.column_drive  = m_axis_tdata[3:0];
            got.scan.scan_done     = m_axis_tlast;
            got.scan.key_word      = m_axis_tdata[19:4];
            got.scan.key_down_mask = m_axis_tdata[35:20];
            got.btn.sys_pressed    = m_axis_tdata[38:36];
            got.btn.sys_flags      = m_axis_tdata[44:39];
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $error("result with no expectation waiting: tdata 0x%0h", m_axis_tdata);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("column_drive", KEY_COUNT'(want.scan.column_drive),
                            KEY_COUNT'(got.scan.column_drive));
                check_field("scan_done", KEY_COUNT'(want.scan.scan_done),
                            KEY_COUNT'(got.scan.scan_done));
                check_field("key_word", want.scan.key_word, got.scan.key_word);
                check_field("key_down_mask", want.scan.key_down_mask,
                            got.scan.key_down_mask);
                check_field("sys_pressed", KEY_COUNT'(want.btn.sys_pressed),
                            KEY_COUNT'(got.btn.sys_pressed));
                check_field("sys_flags", KEY_COUNT'(want.btn.sys_flags),
                            KEY_COUNT'(got.btn.sys_flags));
                check_field("tdata padding", '0, KEY_COUNT'(m_axis_tdata[47:45]));
                if (want.scan.scan_done)
                begin
                    scans_seen++;
                    key_downs_seen += $countones(want.scan.key_down_mask);
                end
            end
        end
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            pending_results.push_back(predict_sample(s_axis_tdata));
            items_sent++;
            item_taken = 1'b1;
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Stimulus and end of run
    initial
    begin
        logic [KEY_COUNT-1:0] rnd_keys;
        logic [BTN_COUNT-1:0] rnd_pins;
        rnd_keys = '0;
        rnd_pins = '1;

        // Directed: idle, everything pressed, clears with and without edges
        push_scan(16'h0000, 3'b111, 6'h00);
        push_scan(16'hFFFF, 3'b000, 6'h00);
        push_scan(16'hFFFF, 3'b111, 6'h3F);
        push_scan(16'h0000, 3'b111, 6'h3F);
        // One key per column, each button pressed and released alone
        push_sample(4'b1110, 3'b110, 6'h00);
        push_sample(4'b1101, 3'b111, 6'h2A);
        push_sample(4'b1011, 3'b101, 6'h00);
        push_sample(4'b0111, 3'b111, 6'h15);
        push_sample(4'b0111, 3'b011, 6'h00);
        push_sample(4'b1011, 3'b111, 6'h00);
        push_sample(4'b1101, 3'b111, 6'h2A);
        push_sample(4'b1110, 3'b111, 6'h15);

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Hold off new items until every result is back
        wait (items_sent == items_queued && pending_results.size() == 0);
        repeat (RANDOM_GROUPS / 2)
        begin
            push_random_group(rnd_keys, rnd_pins);
        end
        wait (items_sent == items_queued && pending_results.size() == 0);
        repeat (RANDOM_GROUPS - RANDOM_GROUPS / 2)
        begin
            push_random_group(rnd_keys, rnd_pins);
        end

        wait (items_sent == items_queued && pending_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d samples, checked %0d results over %0d complete scans.",
                 items_sent, results_seen, scans_seen);
        $display("Saw %0d new key presses; run included clears, bounces and noise.",
                 key_downs_seen);
        if (error_count == 0 && pending_results.size() == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

/* filelist.f */
hdl/kms_pkg.sv
hdl/kms_matrix.sv
hdl/kms_buttons.sv
hdl/keypad_matrix_scanner.sv
tb/sv/tb_top.sv
